[rtl/core/trd_pkg.sv]
// Package for the touch report decoder: shared types and constants.
// Used by every module of the block and by the testbench; no dependencies.
`default_nettype none

package trd_pkg;

    localparam int MAX_POINTS = 2;

    // Byte positions within a burst, counted from the count byte at zero.
    localparam logic [3:0] POS_IDLE = 4'd0;
    localparam logic [3:0] POS_XH0  = 4'd1;
    localparam logic [3:0] POS_XL0  = 4'd2;
    localparam logic [3:0] POS_YH0  = 4'd3;
    localparam logic [3:0] POS_YL0  = 4'd4;
    localparam logic [3:0] POS_XH1  = 4'd7;
    localparam logic [3:0] POS_XL1  = 4'd8;
    localparam logic [3:0] POS_YH1  = 4'd9;
    localparam logic [3:0] POS_YL1  = 4'd10;
    localparam logic [3:0] POS_LAST = 4'd12;

    localparam logic [1:0] ST_POINT    = 2'd0;
    localparam logic [1:0] ST_NO_TOUCH = 2'd1;
    localparam logic [1:0] ST_BAD_CNT  = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_SWAP   = 3'd2;
    localparam logic [2:0] CFG_FLIP_X = 3'd3;
    localparam logic [2:0] CFG_FLIP_Y = 3'd4;

    localparam logic [12:0] SIZE_RESET = 13'd4096;

    typedef struct packed {
        logic [1:0]  ev;
        logic [3:0]  id;
        logic [11:0] y;
        logic [11:0] x;
    } t_point;

    typedef struct packed {
        logic       bad;
        logic [1:0] count;
        t_point     p1;
        t_point     p0;
    } t_job;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  touch_id;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic        swap;
        logic        flip_x;
        logic        flip_y;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

endpackage

`default_nettype wire

[rtl/core/trd_in_if.sv]
// Input channel of the touch report decoder: one burst byte per transaction.
// Depends on nothing but the handshake convention valid and ready.
`default_nettype none

interface trd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source(output valid, output rx_byte, output frame_start, input ready);
    modport sink(input valid, input rx_byte, input frame_start, output ready);
endinterface

`default_nettype wire

[rtl/core/trd_out_if.sv]
// Output channel of the touch report decoder: one decoded result per transaction.
// Depends on nothing but the handshake convention valid and ready.
`default_nettype none

interface trd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  touch_id;
    logic [11:0] raw_x;
    logic [11:0] raw_y;
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic        last;

    modport source(output valid, output status, output touch_id, output raw_x,
                   output raw_y, output out_x, output out_y, output last, input ready);
    modport sink(input valid, input status, input touch_id, input raw_x,
                 input raw_y, input out_x, input out_y, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/touch_report_decoder.sv]
// A burst's first result passes through the queue and then the output register after its final byte is taken.
// Throughput: one byte per cycle but for the stall below; results leave one per cycle while taken, at most two.
// The input stalls at the final byte position only while two finished bursts wait in the queue.
// Reset is synchronous and active low; it clears the burst tracker, the queue, the
// output register and restores the panel size 4096 by 4096 with no swap or mirroring.
// Top level of the touch report decoder; instantiates trd_front, trd_queue, trd_back.
`default_nettype none

module touch_report_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    trd_in_if.sink           i_in,
    trd_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [12:0] i_cfg_data
);

    trd_pkg::t_cfg    r_cfg;
    trd_pkg::t_job    push_job;
    trd_pkg::t_job    head_job;
    trd_pkg::t_q_stat q_stat;
    logic             push;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= trd_pkg::SIZE_RESET;
            r_cfg.height <= trd_pkg::SIZE_RESET;
            r_cfg.swap   <= 1'b0;
            r_cfg.flip_x <= 1'b0;
            r_cfg.flip_y <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                trd_pkg::CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                trd_pkg::CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                trd_pkg::CFG_SWAP:   r_cfg.swap   <= i_cfg_data[0];
                trd_pkg::CFG_FLIP_X: r_cfg.flip_x <= i_cfg_data[0];
                trd_pkg::CFG_FLIP_Y: r_cfg.flip_y <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    trd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_job    (push_job)
    );

    trd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    trd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (head_job),
        .i_head_valid (q_stat.valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );

    // A job is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("job pushed into a full queue");

    // Any result other than a point ends its burst and carries no coordinates.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != trd_pkg::ST_POINT) |->
            (o_out.last && o_out.raw_x == 12'd0 && o_out.touch_id == 4'd0))
        else $error("non-point result is not a lone final result");

    // A popped job must have been at the head of a non-empty queue.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_stat.valid)
        else $error("job popped from an empty queue");

    // The output register is empty right after reset.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result presented straight after reset");

endmodule

`default_nettype wire

[rtl/core/trd_front.sv]
// Front end of the touch report decoder: tracks the byte position in a burst,
// gathers the point records and pushes a finished burst as a job. Uses trd_pkg.
`default_nettype none

module trd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    trd_in_if.sink             i_in,
    input  wire logic          i_q_full,
    output logic               o_push,
    output trd_pkg::t_job      o_job
);

    logic [3:0]      r_pos, n_pos;
    logic            r_bad, n_bad;
    logic [1:0]      r_count, n_count;
    trd_pkg::t_point r_pt0, n_pt0;
    trd_pkg::t_point r_pt1, n_pt1;
    logic            accept;

    assign i_in.ready = !(i_q_full && (r_pos == trd_pkg::POS_LAST));
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept && !i_in.frame_start && (r_pos == trd_pkg::POS_LAST);
    assign o_job      = '{bad: r_bad, count: r_count, p1: r_pt1, p0: r_pt0};

    always_comb begin
        n_pos   = r_pos;
        n_bad   = r_bad;
        n_count = r_count;
        n_pt0   = r_pt0;
        n_pt1   = r_pt1;
        if (accept) begin
            if (i_in.frame_start) begin
                n_pos   = trd_pkg::POS_XH0;
                n_bad   = i_in.rx_byte[3:0] > 4'(trd_pkg::MAX_POINTS);
                n_count = i_in.rx_byte[1:0];
            end else if (r_pos != trd_pkg::POS_IDLE) begin
                n_pos = (r_pos == trd_pkg::POS_LAST) ? trd_pkg::POS_IDLE : r_pos + 4'd1;
                unique case (r_pos)
                    trd_pkg::POS_XH0: begin
                        n_pt0.x[11:8] = i_in.rx_byte[3:0];
                        n_pt0.ev      = i_in.rx_byte[7:6];
                    end
                    trd_pkg::POS_XL0: n_pt0.x[7:0] = i_in.rx_byte;
                    trd_pkg::POS_YH0: begin
                        n_pt0.y[11:8] = i_in.rx_byte[3:0];
                        n_pt0.id      = i_in.rx_byte[7:4];
                    end
                    trd_pkg::POS_YL0: n_pt0.y[7:0] = i_in.rx_byte;
                    trd_pkg::POS_XH1: begin
                        n_pt1.x[11:8] = i_in.rx_byte[3:0];
                        n_pt1.ev      = i_in.rx_byte[7:6];
                    end
                    trd_pkg::POS_XL1: n_pt1.x[7:0] = i_in.rx_byte;
                    trd_pkg::POS_YH1: begin
                        n_pt1.y[11:8] = i_in.rx_byte[3:0];
                        n_pt1.id      = i_in.rx_byte[7:4];
                    end
                    trd_pkg::POS_YL1: n_pt1.y[7:0] = i_in.rx_byte;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= trd_pkg::POS_IDLE;
            r_bad   <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_pos   <= n_pos;
            r_bad   <= n_bad;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt0 <= n_pt0;
        r_pt1 <= n_pt1;
    end

endmodule

`default_nettype wire

[rtl/core/trd_queue.sv]
// Two-entry job queue between the front end and the back end of the decoder.
// Uses the job and status types of trd_pkg.
`default_nettype none

module trd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire trd_pkg::t_job i_job,
    input  wire logic          i_pop,
    output trd_pkg::t_job      o_head,
    output trd_pkg::t_q_stat   o_stat
);

    trd_pkg::t_job r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.valid = (r_cnt != 2'd0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && o_stat.valid;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

[rtl/core/trd_back.sv]
// Back end of the touch report decoder: classifies the points of a job, applies
// the panel transform and drives the registered result channel. Uses trd_pkg.
`default_nettype none

module trd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire trd_pkg::t_cfg i_cfg,
    input  wire trd_pkg::t_job i_head,
    input  wire logic          i_head_valid,
    output logic               o_pop,
    trd_out_if.source          o_out
);

    logic              r_idx;
    logic              r_out_valid;
    trd_pkg::t_result  r_out;
    trd_pkg::t_result  res;
    trd_pkg::t_point   pt;
    logic [1:0]        pressed;
    logic [1:0]        oor;
    logic              range_err;
    logic              two_pts;
    logic              is_last;
    logic              can_load;
    logic              emit;
    logic [11:0]       sx;
    logic [11:0]       sy;
    logic [12:0]       sw;
    logic [12:0]       sh;
    logic [12:0]       mx;
    logic [12:0]       my;

    assign pressed[0] = (i_head.count != 2'd0) && !i_head.p0.ev[0];
    assign pressed[1] = (i_head.count == 2'd2) && !i_head.p1.ev[0];
    assign oor[0] = ({1'b0, i_head.p0.x} >= i_cfg.width) ||
                    ({1'b0, i_head.p0.y} >= i_cfg.height);
    assign oor[1] = ({1'b0, i_head.p1.x} >= i_cfg.width) ||
                    ({1'b0, i_head.p1.y} >= i_cfg.height);
    assign range_err = |(pressed & oor);
    assign two_pts   = &pressed;

    always_comb begin
        if (two_pts) begin
            pt = r_idx ? i_head.p1 : i_head.p0;
        end else begin
            pt = pressed[0] ? i_head.p0 : i_head.p1;
        end
    end

    assign sx = i_cfg.swap ? pt.y : pt.x;
    assign sy = i_cfg.swap ? pt.x : pt.y;
    assign sw = i_cfg.swap ? i_cfg.height : i_cfg.width;
    assign sh = i_cfg.swap ? i_cfg.width : i_cfg.height;
    assign mx = sw - {1'b0, sx} - 13'd1;
    assign my = sh - {1'b0, sy} - 13'd1;

    always_comb begin
        res = '0;
        if (i_head.bad) begin
            res.status = trd_pkg::ST_BAD_CNT;
        end else if (range_err) begin
            res.status = trd_pkg::ST_RANGE;
        end else if (pressed == 2'b00) begin
            res.status = trd_pkg::ST_NO_TOUCH;
        end else begin
            res.status   = trd_pkg::ST_POINT;
            res.touch_id = pt.id;
            res.raw_x    = pt.x;
            res.raw_y    = pt.y;
            res.out_x    = i_cfg.flip_x ? mx[11:0] : sx;
            res.out_y    = i_cfg.flip_y ? my[11:0] : sy;
        end
        res.last = is_last;
    end

    assign is_last  = i_head.bad || range_err || !two_pts || r_idx;
    assign can_load = !r_out_valid || o_out.ready;
    assign emit     = i_head_valid && can_load;
    assign o_pop    = emit && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (can_load) begin
                r_out_valid <= i_head_valid;
            end
            if (emit) begin
                r_idx <= !is_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_out.status;
    assign o_out.touch_id = r_out.touch_id;
    assign o_out.raw_x    = r_out.raw_x;
    assign o_out.raw_y    = r_out.raw_y;
    assign o_out.out_x    = r_out.out_x;
    assign o_out.out_y    = r_out.out_y;
    assign o_out.last     = r_out.last;

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for touch_report_decoder: drives status bursts byte by byte,
// predicts every decoded result and compares each output transaction field by field.
// Depends on trd_pkg, trd_in_if and trd_out_if, and on the decoder itself.

module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int HOLD_OFF    = 4;
    localparam int BURST_LEN   = 13;
    localparam int RECORD_LEN  = 6;

    localparam logic [1:0] EV_PRESS    = 2'd0;
    localparam logic [1:0] EV_LIFT     = 2'd1;
    localparam logic [1:0] EV_CONTACT  = 2'd2;
    localparam logic [1:0] EV_RESERVED = 2'd3;

    localparam int OFF_XH = 0;
    localparam int OFF_XL = 1;
    localparam int OFF_YH = 2;
    localparam int OFF_YL = 3;

    localparam logic [2:0] CFG_UNUSED = 3'd7;

    class touch_scoreboard;
        logic [12:0]      width;
        logic [12:0]      height;
        logic             swap;
        logic             flip_x;
        logic             flip_y;
        logic [3:0]       position;
        logic [3:0]       count;
        logic             bad_count;
        trd_pkg::t_point  store [2];
        trd_pkg::t_result expected_q [$];
        int               mismatches;
        int               bursts_seen;
        int               results_checked;
        int               status_seen [4];

        function new();
            width = trd_pkg::SIZE_RESET;
            height = trd_pkg::SIZE_RESET;
            swap = 1'b0;
            flip_x = 1'b0;
            flip_y = 1'b0;
            position = trd_pkg::POS_IDLE;
            count = '0;
            bad_count = 1'b0;
            mismatches = 0;
            bursts_seen = 0;
            results_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void note_setting(logic [2:0] idx, logic [12:0] data);
            case (idx)
                trd_pkg::CFG_WIDTH:  width  = data;
                trd_pkg::CFG_HEIGHT: height = data;
                trd_pkg::CFG_SWAP:   swap   = data[0];
                trd_pkg::CFG_FLIP_X: flip_x = data[0];
                trd_pkg::CFG_FLIP_Y: flip_y = data[0];
                default: ;
            endcase
        endfunction

        function void push_status(logic [1:0] st);
            trd_pkg::t_result r;
            r = '0;
            r.status = st;
            r.last = 1'b1;
            expected_q.push_back(r);
        endfunction

        function void decode_burst();
            trd_pkg::t_result hits [2];
            trd_pkg::t_point  pt;
            logic [12:0]      w, h, x, y, t;
            int               n;
            n = 0;
            bursts_seen++;
            if (bad_count || count > trd_pkg::MAX_POINTS) begin
                push_status(trd_pkg::ST_BAD_CNT);
                return;
            end
            for (int i = 0; i < count; i++) begin
                pt = store[i];
                if (pt.ev == EV_LIFT || pt.ev == EV_RESERVED) continue;
                w = width;
                h = height;
                x = {1'b0, pt.x};
                y = {1'b0, pt.y};
                if (x >= w || y >= h) begin
                    push_status(trd_pkg::ST_RANGE);
                    return;
                end
                if (swap) begin
                    t = x; x = y; y = t;
                    t = w; w = h; h = t;
                end
                if (flip_x) x = w - 13'd1 - x;
                if (flip_y) y = h - 13'd1 - y;
                hits[n] = '0;
                hits[n].status = trd_pkg::ST_POINT;
                hits[n].touch_id = pt.id;
                hits[n].raw_x = pt.x;
                hits[n].raw_y = pt.y;
                hits[n].out_x = x[11:0];
                hits[n].out_y = y[11:0];
                n++;
            end
            if (n == 0) begin
                push_status(trd_pkg::ST_NO_TOUCH);
            end else begin
                hits[n-1].last = 1'b1;
                for (int i = 0; i < n; i++) expected_q.push_back(hits[i]);
            end
        endfunction

        function void note_byte(logic [7:0] b, logic fs);
            logic [3:0] p;
            int         slot;
            int         off;
            if (fs) begin
                count = b[3:0];
                bad_count = (b[3:0] > trd_pkg::MAX_POINTS);
                position = trd_pkg::POS_XH0;
                return;
            end
            if (position == trd_pkg::POS_IDLE) return;
            p = position - 4'd1;
            slot = p / RECORD_LEN;
            off = p % RECORD_LEN;
            case (off)
                OFF_XH: begin
                    store[slot].ev = b[7:6];
                    store[slot].x[11:8] = b[3:0];
                end
                OFF_XL: store[slot].x[7:0] = b;
                OFF_YH: begin
                    store[slot].id = b[7:4];
                    store[slot].y[11:8] = b[3:0];
                end
                OFF_YL: store[slot].y[7:0] = b;
                default: ;
            endcase
            if (position == trd_pkg::POS_LAST) begin
                position = trd_pkg::POS_IDLE;
                decode_burst();
            end else begin
                position = position + 4'd1;
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH result %0d: %s", results_checked, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [11:0] got, logic [11:0] want);
            if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        task check_result(trd_pkg::t_result got);
            trd_pkg::t_result want;
            results_checked++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction with status %0d", got.status));
                return;
            end
            want = expected_q.pop_front();
            status_seen[want.status]++;
            compare_field("status", 12'(got.status), 12'(want.status));
            compare_field("touch_id", 12'(got.touch_id), 12'(want.touch_id));
            compare_field("raw_x", got.raw_x, want.raw_x);
            compare_field("raw_y", got.raw_y, want.raw_y);
            compare_field("out_x", got.out_x, want.out_x);
            compare_field("out_y", got.out_y, want.out_y);
            compare_field("last", 12'(got.last), 12'(want.last));
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [2:0]       cfg_idx;
    logic [12:0]      cfg_data;
    bit               tx_idle = 1'b1;
    bit               rx_idle = 1'b1;
    int               cycle_count = 0;
    int               configs_used = 0;
    trd_pkg::t_result got;
    touch_scoreboard  sb;

    trd_in_if  in_if();
    trd_out_if out_if();

    touch_report_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.expected_q.size());
            $display("FAIL touch_report_decoder");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) sb.note_byte(in_if.rx_byte, in_if.frame_start);
            if (out_if.valid && out_if.ready) begin
                got.status   = out_if.status;
                got.touch_id = out_if.touch_id;
                got.raw_x    = out_if.raw_x;
                got.raw_y    = out_if.raw_y;
                got.out_x    = out_if.out_x;
                got.out_y    = out_if.out_y;
                got.last     = out_if.last;
                sb.check_result(got);
            end
        end
    end

    initial begin
        int hold;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = rx_idle ? $urandom_range(0, 8) : 0;
            repeat (hold) begin
                out_if.ready <= 1'b0;
                @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_if.valid && out_if.ready)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.rx_byte     <= b;
        in_if.frame_start <= fs;
        @(posedge i_clk);
        while (!(in_if.valid && in_if.ready)) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] cnt,
                              input logic [1:0] ev0, input logic [3:0] id0,
                              input logic [11:0] x0, input logic [11:0] y0,
                              input logic [1:0] ev1, input logic [3:0] id1,
                              input logic [11:0] x1, input logic [11:0] y1,
                              input int len);
        logic [7:0] frame [BURST_LEN];
        logic [1:0] j0, j1;
        j0 = 2'($urandom);
        j1 = 2'($urandom);
        frame[0]  = cnt;
        frame[1]  = {ev0, j0, x0[11:8]};
        frame[2]  = x0[7:0];
        frame[3]  = {id0, y0[11:8]};
        frame[4]  = y0[7:0];
        frame[5]  = 8'($urandom);
        frame[6]  = 8'($urandom);
        frame[7]  = {ev1, j1, x1[11:8]};
        frame[8]  = x1[7:0];
        frame[9]  = {id1, y1[11:8]};
        frame[10] = y1[7:0];
        frame[11] = 8'($urandom);
        frame[12] = 8'($urandom);
        for (int i = 0; i < len; i++) send_byte(frame[i], i == 0);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (HOLD_OFF) @(negedge i_clk);
    endtask

    task automatic drive_reg(input logic [2:0] idx, input logic [12:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        sb.note_setting(idx, data);
        @(negedge i_clk);
    endtask

    task automatic reconfigure(input logic [12:0] w, input logic [12:0] h, input logic s,
                               input logic fx, input logic fy, input bit poke_unused);
        settle();
        drive_reg(trd_pkg::CFG_WIDTH, w);
        drive_reg(trd_pkg::CFG_HEIGHT, h);
        drive_reg(trd_pkg::CFG_SWAP, {12'd0, s});
        drive_reg(trd_pkg::CFG_FLIP_X, {12'd0, fx});
        drive_reg(trd_pkg::CFG_FLIP_Y, {12'd0, fy});
        if (poke_unused) drive_reg(CFG_UNUSED, 13'($urandom));
        cfg_we <= 1'b0;
        configs_used++;
    endtask

    function automatic logic [12:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 13'd0;
            1: return 13'd1;
            2: return trd_pkg::SIZE_RESET;
            3: return 13'($urandom_range(4097, 8191));
            default: return 13'($urandom_range(1, 4095));
        endcase
    endfunction

    function automatic logic [11:0] pick_coord(input logic [12:0] size);
        int lim;
        int r;
        lim = (size == 0) ? 4096 : ((size > 4096) ? 4096 : size);
        r = $urandom_range(0, 99);
        if (r < 10) return 12'($urandom);
        if (r < 20) return 12'(lim - 1);
        if (r < 25) return 12'd0;
        return 12'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [1:0] pick_event();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return EV_PRESS;
        if (r < 80) return EV_CONTACT;
        if (r < 90) return EV_LIFT;
        return EV_RESERVED;
    endfunction

    task automatic random_burst();
        logic [7:0] cnt;
        logic [3:0] id0, id1;
        int         len;
        cnt[7:4] = 4'($urandom);
        cnt[3:0] = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 2))
                                                : 4'($urandom_range(3, 15));
        id0 = 4'($urandom);
        id1 = 4'($urandom);
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, BURST_LEN - 1) : BURST_LEN;
        send_frame(cnt, pick_event(), id0, pick_coord(sb.width), pick_coord(sb.height),
                   pick_event(), id1, pick_coord(sb.width), pick_coord(sb.height), len);
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'b0);
    endtask

    initial begin
        int guard;
        sb = new();
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.rx_byte = '0;
        in_if.frame_start = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_frame(8'h00, EV_PRESS, 4'h1, 12'h010, 12'h020, EV_PRESS, 4'h2, 12'h030, 12'h040, 13);
        send_frame(8'h01, EV_PRESS, 4'h0, 12'h000, 12'h000, EV_CONTACT, 4'h5, 12'h123, 12'h456, 13);
        send_frame(8'hF2, EV_PRESS, 4'hF, 12'hFFF, 12'hFFF, EV_CONTACT, 4'hA, 12'h800, 12'h001, 13);
        send_frame(8'h02, EV_LIFT, 4'h3, 12'h100, 12'h100, EV_RESERVED, 4'h4, 12'h200, 12'h200, 13);
        send_frame(8'h03, EV_PRESS, 4'h3, 12'h100, 12'h100, EV_PRESS, 4'h4, 12'h200, 12'h200, 13);
        send_frame(8'hFF, EV_PRESS, 4'h3, 12'h100, 12'h100, EV_PRESS, 4'h4, 12'h200, 12'h200, 13);
        send_byte(8'hAA, 1'b0);
        send_frame(8'h02, EV_PRESS, 4'h6, 12'h555, 12'hAAA, EV_PRESS, 4'h7, 12'h0F0, 12'hF0F, 5);
        send_frame(8'h01, EV_CONTACT, 4'h9, 12'hABC, 12'h321, EV_PRESS, 4'h8, 12'h111, 12'h222, 13);

        reconfigure(13'd100, 13'd50, 1'b1, 1'b1, 1'b1, 1'b0);
        send_frame(8'h02, EV_PRESS, 4'h3, 12'd10, 12'd20, EV_CONTACT, 4'h9, 12'd99, 12'd49, 13);
        send_frame(8'h01, EV_PRESS, 4'h3, 12'd100, 12'd0, EV_PRESS, 4'h9, 12'd1, 12'd1, 13);
        send_frame(8'h02, EV_PRESS, 4'h3, 12'd0, 12'd50, EV_PRESS, 4'h9, 12'd1, 12'd1, 13);
        send_frame(8'h02, EV_LIFT, 4'h3, 12'hFFF, 12'hFFF, EV_PRESS, 4'hC, 12'd0, 12'd0, 13);
        send_frame(8'h02, EV_PRESS, 4'h3, 12'd5, 12'd5, EV_PRESS, 4'h9, 12'd200, 12'd5, 13);

        reconfigure(13'd0, trd_pkg::SIZE_RESET, 1'b0, 1'b0, 1'b0, 1'b0);
        send_frame(8'h01, EV_PRESS, 4'h1, 12'd0, 12'd0, EV_PRESS, 4'h2, 12'd0, 12'd0, 13);
        send_frame(8'h01, EV_LIFT, 4'h1, 12'd0, 12'd0, EV_PRESS, 4'h2, 12'd0, 12'd0, 13);

        reconfigure(13'd8191, 13'd8191, 1'b0, 1'b1, 1'b1, 1'b1);
        send_frame(8'h02, EV_PRESS, 4'hE, 12'd0, 12'd0, EV_CONTACT, 4'hD, 12'hFFF, 12'hFFF, 13);

        reconfigure(13'd1, 13'd1, 1'b1, 1'b0, 1'b1, 1'b0);
        send_frame(8'h02, EV_PRESS, 4'h7, 12'd0, 12'd0, EV_CONTACT, 4'h8, 12'd0, 12'd0, 13);

        reconfigure(trd_pkg::SIZE_RESET, 13'd1, 1'b0, 1'b1, 1'b0, 1'b0);
        send_frame(8'h01, EV_CONTACT, 4'hB, 12'hFFF, 12'd0, EV_PRESS, 4'h0, 12'd0, 12'd0, 13);

        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 0) begin
                reconfigure(trd_pkg::SIZE_RESET, trd_pkg::SIZE_RESET, 1'b0, 1'b0, 1'b0, 1'b0);
            end else begin
                reconfigure(pick_size(), pick_size(), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ph == 5);
            end
            tx_idle = (ph % 3 != 0);
            rx_idle = (ph % 4 != 1);
            repeat (5) random_burst();
        end

        in_if.valid <= 1'b0;
        guard = 0;
        while (sb.expected_q.size() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (2 * HOLD_OFF) @(negedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived",
                                         sb.expected_q.size()));

        $display("Ran %0d bursts under %0d panel settings, %0d results checked, %0d mismatches.",
                 sb.bursts_seen, configs_used, sb.results_checked, sb.mismatches);
        $display("Results by status: %0d point, %0d no touch, %0d bad count, %0d out of range.",
                 sb.status_seen[trd_pkg::ST_POINT], sb.status_seen[trd_pkg::ST_NO_TOUCH],
                 sb.status_seen[trd_pkg::ST_BAD_CNT], sb.status_seen[trd_pkg::ST_RANGE]);
        if (sb.mismatches == 0) begin
            $display("PASS touch_report_decoder");
        end else begin
            $display("FAIL touch_report_decoder");
        end
        $finish;
    end

endmodule
